FILE: rtl/ladr_pkg.sv
// Shared constants for the anti-diagonal longest-run block.
package ladr_pkg;

    localparam int MAX_SIDE_DEFAULT = 64;

    localparam int SIDE_W      = 7;
    localparam int CELL_W      = 1;
    localparam int RUN_OUT_W   = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

endpackage

FILE: rtl/ladr_scan.sv
// Row and column position counters and anti-diagonal address generation.
module ladr_scan #(
    parameter int MAX_SIDE = ladr_pkg::MAX_SIDE_DEFAULT,
    localparam int POS_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int DIAG_W  = (MAX_SIDE > 1) ? $clog2(2 * MAX_SIDE - 1) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [ladr_pkg::SIDE_W-1:0] side,
    output logic [DIAG_W-1:0]           diag,
    output logic                        last
);

    localparam int MAXV_W = $clog2(MAX_SIDE + 1);
    localparam int CW     = (MAXV_W > ladr_pkg::SIDE_W) ? MAXV_W : ladr_pkg::SIDE_W;

    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [CW-1:0]    side_ext;
    logic [CW-1:0]    eff_side;
    logic             col_end;
    logic             row_end;

    // Clamp the side to 1..MAX_SIDE
    always_comb
    begin
        side_ext = CW'(side);
        if (side_ext == '0)
        begin
            eff_side = CW'(1);
        end
        else if (side_ext > CW'(MAX_SIDE))
        begin
            eff_side = CW'(MAX_SIDE);
        end
        else
        begin
            eff_side = side_ext;
        end
    end

    assign col_end = (CW'(col_reg) + CW'(1)) >= eff_side;
    assign row_end = (CW'(row_reg) + CW'(1)) >= eff_side;
    assign last    = col_end && row_end;
    assign diag    = DIAG_W'(row_reg) + DIAG_W'(col_reg);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (advance)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: rtl/longest_antidiagonal_ones_run.sv
// Top level: longest run of ones along the anti-diagonals of a streamed square matrix.
//
//  channel   | direction | handshake              | content
//  s_*       | in        | s_tvalid / s_tready    | one matrix cell per item, row-major
//  m_*       | out       | m_tvalid / m_tready    | longest run, one item per matrix
//  cfg_*     | in        | cfg_valid / cfg_ready  | matrix side length
//
// One cell per cycle while s_tready is high; the last cell passes stage 1, which does the
// read-increment-write of the per-diagonal run memory, before the result is registered.
// Reset clears positions, run valid bits and best run at once; side resets to 64.
// Input stalls only while a finished result is held and the next one is ready.
// Diagonal run state is dropped at once after each matrix through its valid bits.
module longest_antidiagonal_ones_run #(
    parameter int MAX_SIDE = ladr_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ladr_pkg::S_TDATA_W-1:0] s_tdata,   // [0] cell_bit, [7:1] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ladr_pkg::M_TDATA_W-1:0] m_tdata,   // [6:0] longest_run, [7] zero
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ladr_pkg::SIDE_W-1:0]    cfg_data    // [6:0] matrix_side
);

    localparam int NUM_DIAGS = 2 * MAX_SIDE - 1;
    localparam int DIAG_W    = (MAX_SIDE > 1) ? $clog2(NUM_DIAGS) : 1;
    localparam int RUN_W     = $clog2(MAX_SIDE + 1);

    logic [ladr_pkg::SIDE_W-1:0] side_reg;

    logic [DIAG_W-1:0] scan_diag;
    logic              scan_last;
    logic              in_accept;

    logic [RUN_W-1:0]  run_mem [NUM_DIAGS];
    logic [NUM_DIAGS-1:0] valid_reg;
    logic [RUN_W-1:0]  rd_data_reg;

    logic              s1_valid_reg;
    logic              s1_bit_reg;
    logic              s1_last_reg;
    logic [DIAG_W-1:0] s1_diag_reg;
    logic              rd_ok_reg;
    logic              fwd_reg;
    logic [RUN_W-1:0]  fwd_val_reg;

    logic              s1_advance;
    logic              s1_fire;
    logic [RUN_W-1:0]  s1_prev;
    logic [RUN_W-1:0]  s1_run;
    logic [RUN_W-1:0]  best_cand;
    logic [RUN_W-1:0]  best_reg;

    logic              out_valid_reg;
    logic [RUN_W-1:0]  out_run_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= ladr_pkg::SIDE_RESET;
        end
        else if (cfg_valid)
        begin
            side_reg <= cfg_data;
        end
    end

    // Stage 1 moves unless it holds a result that the output cannot take.
    assign s1_advance = !(s1_valid_reg && s1_last_reg && out_valid_reg && !m_tready);
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign s_tready   = s1_advance;
    assign in_accept  = s_tvalid && s_tready;

    ladr_scan #(
        .MAX_SIDE (MAX_SIDE)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_accept),
        .side    (side_reg),
        .diag    (scan_diag),
        .last    (scan_last)
    );

    // Run of the diagonal before this cell: forwarded, stored, or cleared.
    always_comb
    begin
        if (fwd_reg)
        begin
            s1_prev = fwd_val_reg;
        end
        else if (rd_ok_reg)
        begin
            s1_prev = rd_data_reg;
        end
        else
        begin
            s1_prev = '0;
        end
        s1_run    = s1_bit_reg ? (s1_prev + RUN_W'(1)) : '0;
        best_cand = (s1_run > best_reg) ? s1_run : best_reg;
    end

    // Run memory: write back on a firing cell that does not end a matrix, read for the cell being taken.
    always_ff @(posedge clk)
    begin
        if (s1_fire && !s1_last_reg)
        begin
            run_mem[s1_diag_reg] <= s1_run;
        end
        if (in_accept)
        begin
            rd_data_reg <= run_mem[scan_diag];
            fwd_val_reg <= s1_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            valid_reg <= '0;
        end
        else if (s1_fire)
        begin
            valid_reg[s1_diag_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_bit_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_diag_reg  <= '0;
            rd_ok_reg    <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= in_accept;
            if (in_accept)
            begin
                s1_bit_reg  <= s_tdata[0];
                s1_last_reg <= scan_last;
                s1_diag_reg <= scan_diag;
                // A matrix ending now drops every stored run.
                rd_ok_reg   <= valid_reg[scan_diag] && !(s1_fire && s1_last_reg);
                fwd_reg     <= s1_fire && !s1_last_reg && (s1_diag_reg == scan_diag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (s1_fire)
        begin
            best_reg <= s1_last_reg ? '0 : best_cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_run_reg   <= '0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
            out_run_reg   <= best_cand;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, ladr_pkg::RUN_OUT_W'(out_run_reg)};

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire && s1_last_reg))
        else $error("result raised without a finished matrix");

    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted item did not reach stage 1");

    a_runs_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (valid_reg == '0) && (best_reg == '0))
        else $error("run state not cleared after matrix end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && s1_valid_reg && s1_last_reg) |=> $stable(out_run_reg))
        else $error("held result overwritten");

endmodule

FILE: tb/sv/longest_antidiagonal_ones_run_test.sv
// Self-checking testbench for the anti-diagonal longest-run block.
`timescale 1ns / 100ps

module longest_antidiagonal_ones_run_test;

    localparam int MAX_SIDE    = ladr_pkg::MAX_SIDE_DEFAULT;
    localparam int NUM_DIAGS   = 2 * MAX_SIDE - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [ladr_pkg::S_TDATA_W-1:0]   s_tdata   = '0;    // [0] cell_bit, [7:1] zero
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [ladr_pkg::M_TDATA_W-1:0]   m_tdata;           // [6:0] longest_run, [7] zero
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ladr_pkg::SIDE_W-1:0]      cfg_data  = '0;    // [6:0] matrix_side

    // stimulus side
    bit                               cell_fifo[$];
    int                               cells_pushed   = 0;
    int                               cells_taken    = 0;
    bit                               cell_accepted  = 1'b0;
    int                               send_idle_pct  = 0;
    int                               recv_stall_pct = 0;

    // predicted block state
    logic [ladr_pkg::SIDE_W-1:0]      side_setting = ladr_pkg::SIDE_RESET;
    logic [ladr_pkg::RUN_OUT_W-1:0]   diag_run[NUM_DIAGS];
    logic [5:0]                       cur_row      = '0;
    logic [5:0]                       cur_col      = '0;
    logic [ladr_pkg::RUN_OUT_W-1:0]   best_so_far  = '0;
    logic [ladr_pkg::RUN_OUT_W-1:0]   expected_runs[$];

    int                               mismatch_count = 0;
    int                               cycle_count    = 0;

    longest_antidiagonal_ones_run #(
        .MAX_SIDE (MAX_SIDE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int clamp_side(input logic [ladr_pkg::SIDE_W-1:0] s);
        if (s < 1)
            return 1;
        if (s > MAX_SIDE)
            return MAX_SIDE;
        return int'(s);
    endfunction

    function automatic void clear_matrix();
        foreach (diag_run[i])
            diag_run[i] = '0;
        cur_row     = '0;
        cur_col     = '0;
        best_so_far = '0;
    endfunction

    // Advance the predicted state by one cell; return 1 when the matrix closes.
    function automatic bit step_matrix_cell(input bit cell_val,
                                            output logic [ladr_pkg::RUN_OUT_W-1:0] run);
        int eff;
        int d;
        eff = clamp_side(side_setting);
        d   = int'(cur_row) + int'(cur_col);
        run = '0;
        if (cell_val)
        begin
            diag_run[d] = diag_run[d] + 1'b1;
            if (diag_run[d] > best_so_far)
                best_so_far = diag_run[d];
        end
        else
        begin
            diag_run[d] = '0;
        end
        if (int'(cur_col) + 1 >= eff)
        begin
            cur_col = '0;
            if (int'(cur_row) + 1 >= eff)
            begin
                run = best_so_far;
                clear_matrix();
                return 1'b1;
            end
            cur_row = cur_row + 1'b1;
        end
        else
        begin
            cur_col = cur_col + 1'b1;
        end
        return 1'b0;
    endfunction

    // Cells still needed to close the matrix from a given position and side.
    function automatic int cells_left(input int row, input int col, input int eff);
        int n;
        n = 0;
        forever
        begin
            n++;
            if (col + 1 >= eff)
            begin
                col = 0;
                if (row + 1 >= eff)
                    return n;
                row++;
            end
            else
            begin
                col++;
            end
        end
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [ladr_pkg::RUN_OUT_W-1:0] got,
                                   input logic [ladr_pkg::RUN_OUT_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Predict on accepted cells, check accepted results.
    always @(posedge clk)
    begin
        logic [ladr_pkg::RUN_OUT_W-1:0] run;
        logic [ladr_pkg::RUN_OUT_W-1:0] want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                side_setting = cfg_data;
            cell_accepted <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                cells_taken <= cells_taken + 1;
                if (step_matrix_cell(s_tdata[0], run))
                    expected_runs.push_back(run);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_runs.size() == 0)
                begin
                    report_mismatch("result with none pending",
                                    m_tdata[ladr_pkg::RUN_OUT_W-1:0], 'x);
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (m_tdata[ladr_pkg::RUN_OUT_W-1:0] !== want)
                        report_mismatch("longest_run", m_tdata[ladr_pkg::RUN_OUT_W-1:0], want);
                end
            end
        end
    end

    // Cell driver: hold until taken, then load the next cell or idle.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || cell_accepted))
        begin
            if (cell_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tdata  <= {{(ladr_pkg::S_TDATA_W-1){1'b0}}, cell_fifo.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic push_cell(input bit b);
        cell_fifo.push_back(b);
        cells_pushed++;
    endtask

    task automatic push_pattern(input logic [31:0] bits, input int n);
        for (int i = 0; i < n; i++)
            push_cell(bits[i]);
    endtask

    task automatic push_random(input int n, input int ones_pct);
        for (int i = 0; i < n; i++)
            push_cell($urandom_range(99) < ones_pct);
    endtask

    // Wait until every cell is taken and every result is back, then let the block go quiet.
    task automatic settle();
        while (cells_taken != cells_pushed || expected_runs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_side(input logic [ladr_pkg::SIDE_W-1:0] v);
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                          phase_cells;
        int                          eff;
        int                          m;
        int                          n;
        int                          dens;
        logic [ladr_pkg::SIDE_W-1:0] side;

        clear_matrix();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 24;
        recv_stall_pct = 84;

        // Reset side, then shrink mid-matrix past the current column.
        push_pattern(32'b111, 3);
        settle();
        write_side(7'd2);
        push_pattern(32'b11, cells_left(int'(cur_row), int'(cur_col), 2));

        // Zero side acts as one: every cell closes a matrix.
        settle();
        write_side(7'd0);
        push_pattern(32'b01, 2);

        // Full anti-diagonal of ones.
        settle();
        write_side(7'd3);
        push_pattern(32'b001010100, 9);

        // Grow mid-matrix.
        settle();
        write_side(7'd2);
        push_pattern(32'b11, 2);
        settle();
        write_side(7'd3);
        push_pattern(32'hFFFF_FFFF, cells_left(int'(cur_row), int'(cur_col), 3));

        for (int ph = 0; ph < 3; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 84;
                end
                1:
                begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 24;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (ph == 2)
            begin
                // Oversize side clamps: the row wraps at MAX_SIDE, then a small side ends it.
                write_side(7'd127);
                push_random(MAX_SIDE + 3, 100);
                settle();
                write_side(7'd2);
                push_random(cells_left(int'(cur_row), int'(cur_col), 2), 100);
                settle();
                // Full side, broken off two cells into the third row.
                write_side(ladr_pkg::SIDE_W'(MAX_SIDE));
                push_random(2 * MAX_SIDE + 2, 90);
                settle();
                write_side(7'd1);
                push_random(cells_left(int'(cur_row), int'(cur_col), 1), 90);
                settle();
            end
            phase_cells = 0;
            while (phase_cells < 320)
            begin
                settle();
                side = ($urandom_range(9) < 8) ? ladr_pkg::SIDE_W'($urandom_range(0, 8))
                                               : ladr_pkg::SIDE_W'($urandom_range(9, 16));
                write_side(side);
                repeat ($urandom_range(1, 4))
                begin
                    eff = clamp_side(side);
                    case ($urandom_range(3))
                        0:       dens = 25;
                        1:       dens = 50;
                        2:       dens = 75;
                        default: dens = 95;
                    endcase
                    if ($urandom_range(5) == 0 && eff * eff > 1)
                    begin
                        // Break off a matrix, change the side, and finish it.
                        m = $urandom_range(1, eff * eff - 1);
                        push_random(m, dens);
                        settle();
                        side = ladr_pkg::SIDE_W'($urandom_range(0, 10));
                        write_side(side);
                        n = cells_left(int'(cur_row), int'(cur_col), clamp_side(side));
                        push_random(n, dens);
                        phase_cells += m + n;
                    end
                    else
                    begin
                        push_random(eff * eff, dens);
                        phase_cells += eff * eff;
                    end
                end
            end
        end

        settle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && expected_runs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
